// ===== src/bfha_pkg.sv =====
// ----------------------------------------------------------------------------
// bfha_pkg: shared types and constants of the best-fit heap allocator
// Block tag layout, result codes and the request struct of the tag memory.
// ----------------------------------------------------------------------------
`default_nettype none

package bfha_pkg;

  // default arena size in bytes and hole list depth
  localparam int unsigned HEAP_BYTES_DEF = 65536;
  localparam int unsigned FREE_SLOTS_DEF = 1024;

  // tag offsets: wide enough for a block offset plus any 32-bit size
  localparam int unsigned OFS_W = 35;
  typedef logic [OFS_W-1:0] ofs_t;

  // boundary tag layout
  localparam logic [31:0] TAG_MAGIC   = 32'hFEFA_FEA1;
  localparam int unsigned HDR_BYTES   = 12;
  localparam int unsigned FTR_BYTES   = 8;
  localparam int unsigned OVERHEAD    = HDR_BYTES + FTR_BYTES;
  localparam int unsigned SPLIT_SLACK = 4;
  localparam int unsigned SPLIT_MIN   = OVERHEAD + SPLIT_SLACK;

  typedef enum logic [0:0] {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_OOM    = 2'd1,
    ST_REJECT = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  // one 32-bit little-endian access at any byte offset
  typedef struct packed {
    logic        en;
    logic        we;
    ofs_t        off;
    logic [31:0] wdata;
  } tag_req_t;

  typedef struct packed {
    logic [31:0] payload_address;
    status_e     status;
  } result_t;

endpackage

`default_nettype wire

// ===== src/bfha_if.sv =====
// ----------------------------------------------------------------------------
// bfha_if: valid/ready channels of the allocator
// Request, response and heap base configuration channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfha_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] amount;
  logic [31:0] free_address;

  modport source (output valid, mode, amount, free_address, input ready);
  modport sink   (input valid, mode, amount, free_address, output ready);
endinterface

interface bfha_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] payload_address;
  logic [1:0]  status;

  modport source (output valid, payload_address, status, input ready);
  modport sink   (input valid, payload_address, status, output ready);
endinterface

interface bfha_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] heap_base;

  modport source (output valid, heap_base, input ready);
  modport sink   (input valid, heap_base, output ready);
endinterface

`default_nettype wire

// ===== src/bfha_tag_mem.sv =====
// ----------------------------------------------------------------------------
// bfha_tag_mem: byte arena holding the boundary tags
// Four byte-wide banks interleaved on the low address bits, so one unaligned
// 32-bit word is read or written per cycle. Bytes past the arena read as zero
// and are not written. Read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bfha_tag_mem import bfha_pkg::*; #(
  parameter int unsigned HEAP_BYTES = HEAP_BYTES_DEF
) (
  input  logic        clk_i,
  input  tag_req_t    req_i,
  output logic [31:0] rdata_o
);

  localparam int unsigned ROWS = (HEAP_BYTES + 3) / 4;
  localparam int unsigned RW   = $clog2(ROWS);

  logic [7:0] rd_byte_w [4];
  logic [1:0] off_q;

  // byte lane k of the word lands in bank (off + k) mod 4
  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [7:0]    mem_q [ROWS];
    logic [7:0]    byte_q;
    logic [1:0]    sel_w;
    ofs_t          p_w;
    logic          inr_w;
    logic [RW-1:0] row_w;

    assign sel_w = 2'(k) - req_i.off[1:0];
    assign p_w   = req_i.off + ofs_t'(sel_w);
    assign inr_w = p_w < ofs_t'(HEAP_BYTES);
    assign row_w = inr_w ? p_w[RW+1:2] : '0;

    always_ff @(posedge clk_i) begin
      if (req_i.en && req_i.we && inr_w) begin
        mem_q[row_w] <= req_i.wdata[{sel_w, 3'b000} +: 8];
      end
      if (req_i.en && !req_i.we) begin
        byte_q <= inr_w ? mem_q[row_w] : 8'h00;
      end
    end

    assign rd_byte_w[k] = byte_q;
  end

  always_ff @(posedge clk_i) begin
    if (req_i.en && !req_i.we) begin
      off_q <= req_i.off[1:0];
    end
  end

  // rotate banks back into byte order
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rdata_o[8*i +: 8] = rd_byte_w[2'(i) + off_q];
    end
  end

endmodule

`default_nettype wire

// ===== src/bfha_hole_mem.sv =====
// ----------------------------------------------------------------------------
// bfha_hole_mem: size-sorted list of hole header offsets
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bfha_hole_mem import bfha_pkg::*; #(
  parameter int unsigned FREE_SLOTS = FREE_SLOTS_DEF,
  localparam int unsigned IW = $clog2(FREE_SLOTS)
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [IW-1:0] rd_addr_i,
  output logic [15:0]   rd_data_o,
  input  logic          wr_en_i,
  input  logic [IW-1:0] wr_addr_i,
  input  logic [15:0]   wr_data_i
);

  logic [15:0] mem_q [FREE_SLOTS];
  logic [15:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== src/bfha_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfha_ctrl: allocator sequencer
// Clears and seeds the arena after reset, then runs allocate and free
// requests as sequences of single tag accesses and hole list steps, with
// footer, insert, remove and drop as shared subroutines.
// ----------------------------------------------------------------------------
`default_nettype none

module bfha_ctrl import bfha_pkg::*; #(
  parameter int unsigned HEAP_BYTES = HEAP_BYTES_DEF,
  parameter int unsigned FREE_SLOTS = FREE_SLOTS_DEF,
  localparam int unsigned IW = $clog2(FREE_SLOTS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [31:0]   heap_base_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          mode_i,
  input  logic [15:0]   amount_i,
  input  logic [31:0]   free_address_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output result_t       res_o,
  output tag_req_t      tag_req_o,
  input  logic [31:0]   tag_rdata_i,
  output logic          hole_rd_en_o,
  output logic [IW-1:0] hole_rd_addr_o,
  input  logic [15:0]   hole_rdata_i,
  output logic          hole_wr_en_o,
  output logic [IW-1:0] hole_wr_addr_o,
  output logic [15:0]   hole_wr_data_o
);

  localparam int unsigned ROWS = (HEAP_BYTES + 3) / 4;
  localparam int unsigned RW   = $clog2(ROWS);
  localparam int unsigned CW   = $clog2(FREE_SLOTS + 1);

  typedef enum logic [5:0] {
    S_CLR, S_IMAG, S_IHOL, S_ISIZ, S_IFM, S_IFO, S_IDLE,
    S_A_SCAN, S_A_HRD, S_A_SRD, S_A_SPL, S_A_H1, S_A_H2, S_A_H3,
    S_A_F2, S_A_INS, S_A_CLR,
    S_F_MAG, S_F_HOL, S_F_RS, S_F_RS2, S_F_RH, S_F_M1, S_F_M2, S_F_M3,
    S_F_LEFT, S_F_L2, S_F_L3, S_F_L4, S_F_L5, S_F_L6, S_F_INS, S_F_FIN,
    S_FT_RD, S_FT_W1, S_FT_W2,
    S_I_CHK, S_I_SZ, S_I_SCAN, S_I_H, S_I_C, S_I_SH, S_I_SW,
    S_R_CHK, S_R_W, S_D_SCAN, S_D_CMP, S_DONE
  } state_e;

  state_e        state_q, ret_q, drop_ret_q;
  logic [RW-1:0] clr_q;
  logic [CW-1:0] cnt_q, pos_q, j_q;
  logic [15:0]   amount_q;
  ofs_t          h_q, nh_q, fh_q, ih_q, f_q;
  logic [31:0]   s_q, t_q, sz_q;
  logic          ins_ok_q;
  result_t       res_q;

  ofs_t        heap_w, hole_ofs_w, foot_w, free_h_w, nh_w, split_nh_w;
  logic [32:0] lo_w;
  logic [31:0] diff_w, first_w, payload_w;
  logic        free_rej_w, fits_w, split_w, hole_byte_w, accept_w;

  // address and fit arithmetic
  assign heap_w      = ofs_t'(HEAP_BYTES);
  assign hole_ofs_w  = ofs_t'(hole_rdata_i) + ofs_t'(8);
  assign foot_w      = fh_q + ofs_t'(tag_rdata_i) - ofs_t'(FTR_BYTES);
  assign nh_w        = h_q + ofs_t'(tag_rdata_i);
  assign lo_w        = {1'b0, heap_base_i} + 33'(HDR_BYTES);
  assign diff_w      = free_address_i - heap_base_i;
  assign free_rej_w  = ({1'b0, free_address_i} < lo_w) || (ofs_t'(diff_w) > heap_w);
  assign free_h_w    = ofs_t'(diff_w) - ofs_t'(HDR_BYTES);
  assign fits_w      = (tag_rdata_i >= 32'(OVERHEAD))
                    && ((tag_rdata_i - 32'(OVERHEAD)) > {16'h0000, amount_q});
  assign payload_w   = s_q - 32'(OVERHEAD);
  assign split_w     = (payload_w - {16'h0000, amount_q}) > 32'(SPLIT_MIN);
  assign first_w     = {16'h0000, amount_q} + 32'(OVERHEAD);
  assign split_nh_w  = h_q + ofs_t'(first_w);
  assign hole_byte_w = tag_rdata_i[7:0] != 8'h00;
  assign accept_w    = in_valid_i && in_ready_o;

  assign in_ready_o  = state_q == S_IDLE;
  assign res_valid_o = state_q == S_DONE;
  assign res_o       = res_q;

  // memory requests of the current step
  always_comb begin
    tag_req_o      = '0;
    hole_rd_en_o   = 1'b0;
    hole_rd_addr_o = '0;
    hole_wr_en_o   = 1'b0;
    hole_wr_addr_o = '0;
    hole_wr_data_o = '0;
    unique case (state_q)
      S_CLR:  tag_req_o = '{en: 1'b1, we: 1'b1, off: ofs_t'({clr_q, 2'b00}), wdata: '0};
      S_IMAG: tag_req_o = '{en: 1'b1, we: 1'b1, off: '0, wdata: TAG_MAGIC};
      S_IHOL: tag_req_o = '{en: 1'b1, we: 1'b1, off: ofs_t'(4), wdata: 32'd1};
      S_ISIZ: tag_req_o = '{en: 1'b1, we: 1'b1, off: ofs_t'(8), wdata: 32'(HEAP_BYTES)};
      S_IFM:  tag_req_o = '{en: 1'b1, we: 1'b1, off: heap_w - ofs_t'(8), wdata: TAG_MAGIC};
      S_IFO: begin
        tag_req_o      = '{en: 1'b1, we: 1'b1, off: heap_w - ofs_t'(4), wdata: '0};
        hole_wr_en_o   = 1'b1;
      end
      S_IDLE: begin
        if (accept_w && mode_i == MODE_FREE && !free_rej_w) begin
          tag_req_o = '{en: 1'b1, we: 1'b0, off: free_h_w, wdata: '0};
        end
      end
      S_A_SCAN, S_I_SCAN, S_D_SCAN: begin
        hole_rd_en_o   = pos_q < cnt_q;
        hole_rd_addr_o = pos_q[IW-1:0];
      end
      S_A_HRD, S_I_H: tag_req_o = '{en: 1'b1, we: 1'b0, off: hole_ofs_w, wdata: '0};
      S_A_SPL: begin
        if (split_w) begin
          tag_req_o = '{en: 1'b1, we: 1'b1, off: h_q + ofs_t'(8), wdata: first_w};
        end
      end
      S_A_H1: tag_req_o = '{en: 1'b1, we: 1'b1, off: nh_q, wdata: TAG_MAGIC};
      S_A_H2: tag_req_o = '{en: 1'b1, we: 1'b1, off: nh_q + ofs_t'(4), wdata: 32'd1};
      S_A_H3: tag_req_o = '{en: 1'b1, we: 1'b1, off: nh_q + ofs_t'(8), wdata: s_q - first_w};
      S_A_CLR: tag_req_o = '{en: 1'b1, we: 1'b1, off: h_q + ofs_t'(4), wdata: '0};
      S_F_MAG: tag_req_o = '{en: 1'b1, we: 1'b0, off: h_q + ofs_t'(4), wdata: '0};
      S_F_HOL: begin
        if (!hole_byte_w) begin
          tag_req_o = '{en: 1'b1, we: 1'b1, off: h_q + ofs_t'(4), wdata: 32'd1};
        end
      end
      S_F_RS, S_F_M1, S_F_L5: tag_req_o = '{en: 1'b1, we: 1'b0, off: h_q + ofs_t'(8), wdata: '0};
      S_F_RS2: begin
        if (nh_w < heap_w) begin
          tag_req_o = '{en: 1'b1, we: 1'b0, off: nh_w + ofs_t'(4), wdata: '0};
        end
      end
      S_F_M2, S_F_L4: tag_req_o = '{en: 1'b1, we: 1'b0, off: nh_q + ofs_t'(8), wdata: '0};
      S_F_M3: tag_req_o = '{en: 1'b1, we: 1'b1, off: h_q + ofs_t'(8), wdata: t_q + tag_rdata_i};
      S_F_LEFT: begin
        if (h_q >= ofs_t'(FTR_BYTES)) begin
          tag_req_o = '{en: 1'b1, we: 1'b0, off: h_q - ofs_t'(4), wdata: '0};
        end
      end
      S_F_L2: begin
        if (ofs_t'(tag_rdata_i) < heap_w) begin
          tag_req_o = '{en: 1'b1, we: 1'b0, off: ofs_t'(tag_rdata_i) + ofs_t'(4), wdata: '0};
        end
      end
      S_F_L6: tag_req_o = '{en: 1'b1, we: 1'b1, off: nh_q + ofs_t'(8), wdata: t_q + tag_rdata_i};
      S_FT_RD: tag_req_o = '{en: 1'b1, we: 1'b0, off: fh_q + ofs_t'(8), wdata: '0};
      S_FT_W1: tag_req_o = '{en: 1'b1, we: 1'b1, off: foot_w, wdata: TAG_MAGIC};
      S_FT_W2: tag_req_o = '{en: 1'b1, we: 1'b1, off: f_q + ofs_t'(4), wdata: fh_q[31:0]};
      S_I_CHK: begin
        if (cnt_q < CW'(FREE_SLOTS)) begin
          tag_req_o = '{en: 1'b1, we: 1'b0, off: ih_q + ofs_t'(8), wdata: '0};
        end
      end
      S_I_SH: begin
        if (j_q > pos_q) begin
          hole_rd_en_o   = 1'b1;
          hole_rd_addr_o = IW'(j_q - CW'(1));
        end else begin
          hole_wr_en_o   = 1'b1;
          hole_wr_addr_o = pos_q[IW-1:0];
          hole_wr_data_o = ih_q[15:0];
        end
      end
      S_I_SW, S_R_W: begin
        hole_wr_en_o   = 1'b1;
        hole_wr_addr_o = j_q[IW-1:0];
        hole_wr_data_o = hole_rdata_i;
      end
      S_R_CHK: begin
        hole_rd_en_o   = (j_q + CW'(1)) < cnt_q;
        hole_rd_addr_o = IW'(j_q + CW'(1));
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLR;
      ret_q      <= S_IDLE;
      drop_ret_q <= S_IDLE;
      clr_q      <= '0;
      cnt_q      <= '0;
      pos_q      <= '0;
      j_q        <= '0;
      ins_ok_q   <= 1'b0;
    end else begin
      unique case (state_q)
        // clearing pass, then the whole-arena hole
        S_CLR: begin
          clr_q <= clr_q + RW'(1);
          if (clr_q == RW'(ROWS - 1)) state_q <= S_IMAG;
        end
        S_IMAG: state_q <= S_IHOL;
        S_IHOL: state_q <= S_ISIZ;
        S_ISIZ: state_q <= S_IFM;
        S_IFM:  state_q <= S_IFO;
        S_IFO: begin
          cnt_q   <= CW'(1);
          state_q <= S_IDLE;
        end

        S_IDLE: begin
          if (accept_w) begin
            amount_q <= amount_i;
            pos_q    <= '0;
            h_q      <= free_h_w;
            if (mode_i == MODE_ALLOC) begin
              state_q <= S_A_SCAN;
            end else if (free_rej_w) begin
              res_q   <= '{payload_address: '0, status: ST_REJECT};
              state_q <= S_DONE;
            end else begin
              state_q <= S_F_MAG;
            end
          end
        end

        // allocate: first listed hole that fits
        S_A_SCAN: begin
          if (pos_q < cnt_q) begin
            state_q <= S_A_HRD;
          end else begin
            res_q   <= '{payload_address: '0, status: ST_OOM};
            state_q <= S_DONE;
          end
        end
        S_A_HRD: begin
          h_q     <= ofs_t'(hole_rdata_i);
          state_q <= S_A_SRD;
        end
        S_A_SRD: begin
          s_q <= tag_rdata_i;
          if (fits_w) begin
            j_q     <= pos_q;
            ret_q   <= S_A_SPL;
            state_q <= S_R_CHK;
          end else begin
            pos_q   <= pos_q + CW'(1);
            state_q <= S_A_SCAN;
          end
        end
        S_A_SPL: begin
          nh_q    <= split_nh_w;
          state_q <= split_w ? S_A_H1 : S_A_CLR;
        end
        S_A_H1: state_q <= S_A_H2;
        S_A_H2: state_q <= S_A_H3;
        S_A_H3: begin
          fh_q    <= h_q;
          ret_q   <= S_A_F2;
          state_q <= S_FT_RD;
        end
        S_A_F2: begin
          fh_q    <= nh_q;
          ret_q   <= S_A_INS;
          state_q <= S_FT_RD;
        end
        S_A_INS: begin
          ih_q    <= nh_q;
          ret_q   <= S_A_CLR;
          state_q <= S_I_CHK;
        end
        S_A_CLR: begin
          res_q   <= '{payload_address: heap_base_i + h_q[31:0] + 32'(HDR_BYTES),
                      status: ST_OK};
          state_q <= S_DONE;
        end

        // free: header check, right merge, left merge, relist
        S_F_MAG: begin
          if (tag_rdata_i != TAG_MAGIC) begin
            res_q   <= '{payload_address: '0, status: ST_REJECT};
            state_q <= S_DONE;
          end else begin
            state_q <= S_F_HOL;
          end
        end
        S_F_HOL: begin
          if (hole_byte_w) begin
            res_q   <= '{payload_address: '0, status: ST_REJECT};
            state_q <= S_DONE;
          end else begin
            state_q <= S_F_RS;
          end
        end
        S_F_RS: state_q <= S_F_RS2;
        S_F_RS2: begin
          nh_q    <= nh_w;
          state_q <= (nh_w < heap_w) ? S_F_RH : S_F_LEFT;
        end
        S_F_RH: begin
          if (hole_byte_w) begin
            pos_q      <= '0;
            drop_ret_q <= S_F_M1;
            state_q    <= S_D_SCAN;
          end else begin
            state_q <= S_F_LEFT;
          end
        end
        S_F_M1: state_q <= S_F_M2;
        S_F_M2: begin
          t_q     <= tag_rdata_i;
          state_q <= S_F_M3;
        end
        S_F_M3: begin
          fh_q    <= h_q;
          ret_q   <= S_F_LEFT;
          state_q <= S_FT_RD;
        end
        S_F_LEFT: state_q <= (h_q >= ofs_t'(FTR_BYTES)) ? S_F_L2 : S_F_INS;
        S_F_L2: begin
          nh_q    <= ofs_t'(tag_rdata_i);
          state_q <= (ofs_t'(tag_rdata_i) < heap_w) ? S_F_L3 : S_F_INS;
        end
        S_F_L3: begin
          if (hole_byte_w) begin
            pos_q      <= '0;
            drop_ret_q <= S_F_L4;
            state_q    <= S_D_SCAN;
          end else begin
            state_q <= S_F_INS;
          end
        end
        S_F_L4: state_q <= S_F_L5;
        S_F_L5: begin
          t_q     <= tag_rdata_i;
          state_q <= S_F_L6;
        end
        S_F_L6: begin
          h_q     <= nh_q;
          fh_q    <= nh_q;
          ret_q   <= S_F_INS;
          state_q <= S_FT_RD;
        end
        S_F_INS: begin
          ih_q    <= h_q;
          ret_q   <= S_F_FIN;
          state_q <= S_I_CHK;
        end
        S_F_FIN: begin
          res_q   <= '{payload_address: '0, status: ins_ok_q ? ST_OK : ST_FULL};
          state_q <= S_DONE;
        end

        // footer: magic and header offset at header + size - 8
        S_FT_RD: state_q <= S_FT_W1;
        S_FT_W1: begin
          f_q     <= foot_w;
          state_q <= S_FT_W2;
        end
        S_FT_W2: state_q <= ret_q;

        // insert after all entries of equal or smaller size
        S_I_CHK: begin
          if (cnt_q < CW'(FREE_SLOTS)) begin
            state_q <= S_I_SZ;
          end else begin
            ins_ok_q <= 1'b0;
            state_q  <= ret_q;
          end
        end
        S_I_SZ: begin
          sz_q    <= tag_rdata_i;
          pos_q   <= '0;
          state_q <= S_I_SCAN;
        end
        S_I_SCAN: begin
          if (pos_q < cnt_q) begin
            state_q <= S_I_H;
          end else begin
            j_q     <= cnt_q;
            state_q <= S_I_SH;
          end
        end
        S_I_H: state_q <= S_I_C;
        S_I_C: begin
          if (tag_rdata_i <= sz_q) begin
            pos_q   <= pos_q + CW'(1);
            state_q <= S_I_SCAN;
          end else begin
            j_q     <= cnt_q;
            state_q <= S_I_SH;
          end
        end
        S_I_SH: begin
          if (j_q > pos_q) begin
            state_q <= S_I_SW;
          end else begin
            cnt_q    <= cnt_q + CW'(1);
            ins_ok_q <= 1'b1;
            state_q  <= ret_q;
          end
        end
        S_I_SW: begin
          j_q     <= j_q - CW'(1);
          state_q <= S_I_SH;
        end

        // remove entry j, closing the gap
        S_R_CHK: begin
          if ((j_q + CW'(1)) < cnt_q) begin
            state_q <= S_R_W;
          end else begin
            cnt_q   <= cnt_q - CW'(1);
            state_q <= ret_q;
          end
        end
        S_R_W: begin
          j_q     <= j_q + CW'(1);
          state_q <= S_R_CHK;
        end

        // drop the entry equal to nh, if listed
        S_D_SCAN: state_q <= (pos_q < cnt_q) ? S_D_CMP : drop_ret_q;
        S_D_CMP: begin
          if (ofs_t'(hole_rdata_i) == nh_q) begin
            j_q     <= pos_q;
            ret_q   <= drop_ret_q;
            state_q <= S_R_CHK;
          end else begin
            pos_q   <= pos_q + CW'(1);
            state_q <= S_D_SCAN;
          end
        end

        S_DONE: begin
          if (res_ready_i) state_q <= S_IDLE;
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/best_fit_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// best_fit_heap_allocator: best-fit boundary-tag heap allocator
// Keeps block tags in an on-chip byte arena and a size-sorted hole list.
//
//   channel  dir  beat contents
//   req_i    in   mode, amount, free_address
//   rsp_o    out  payload_address, status
//   cfg_i    in   heap_base
//
// After reset a clearing pass over the (HEAP_BYTES+3)/4 arena rows and the
// seeding of the whole-arena hole run before the first request beat is
// taken; cfg_i is open then. A request steps through each hole list entry
// it visits: it scans entries on allocate, shifts them on remove or insert
// and compares them on insert. The single tag memory port and the single
// hole list port serialize these steps.
// One request is in work at a time; a new one is taken while the previous
// response still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module best_fit_heap_allocator import bfha_pkg::*; #(
  parameter int unsigned HEAP_BYTES = HEAP_BYTES_DEF,
  parameter int unsigned FREE_SLOTS = FREE_SLOTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bfha_req_if.sink   req_i,
  bfha_rsp_if.source rsp_o,
  bfha_cfg_if.sink   cfg_i
);

  localparam int unsigned IW = $clog2(FREE_SLOTS);

  logic [31:0]   heap_base_q;
  logic          rsp_valid_q;
  result_t       rsp_q;
  logic          res_valid, res_ready, in_ready;
  result_t       res;
  tag_req_t      tag_req;
  logic [31:0]   tag_rdata;
  logic          hole_rd_en, hole_wr_en;
  logic [IW-1:0] hole_rd_addr, hole_wr_addr;
  logic [15:0]   hole_rdata, hole_wr_data;

  // heap base register
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q <= '0;
    end else if (cfg_i.valid) begin
      heap_base_q <= cfg_i.heap_base;
    end
  end

  // response output register
  assign res_ready = !rsp_valid_q || rsp_o.ready;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (res_ready) begin
      rsp_valid_q <= res_valid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      rsp_q <= res;
    end
  end

  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.payload_address = rsp_q.payload_address;
  assign rsp_o.status          = rsp_q.status;
  assign req_i.ready           = in_ready;

  bfha_ctrl #(
    .HEAP_BYTES(HEAP_BYTES),
    .FREE_SLOTS(FREE_SLOTS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .heap_base_i   (heap_base_q),
    .in_valid_i    (req_i.valid),
    .in_ready_o    (in_ready),
    .mode_i        (req_i.mode),
    .amount_i      (req_i.amount),
    .free_address_i(req_i.free_address),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .tag_req_o     (tag_req),
    .tag_rdata_i   (tag_rdata),
    .hole_rd_en_o  (hole_rd_en),
    .hole_rd_addr_o(hole_rd_addr),
    .hole_rdata_i  (hole_rdata),
    .hole_wr_en_o  (hole_wr_en),
    .hole_wr_addr_o(hole_wr_addr),
    .hole_wr_data_o(hole_wr_data)
  );

  bfha_tag_mem #(
    .HEAP_BYTES(HEAP_BYTES)
  ) u_tag_mem (
    .clk_i  (clk_i),
    .req_i  (tag_req),
    .rdata_o(tag_rdata)
  );

  bfha_hole_mem #(
    .FREE_SLOTS(FREE_SLOTS)
  ) u_hole_mem (
    .clk_i    (clk_i),
    .rd_en_i  (hole_rd_en),
    .rd_addr_i(hole_rd_addr),
    .rd_data_o(hole_rdata),
    .wr_en_i  (hole_wr_en),
    .wr_addr_i(hole_wr_addr),
    .wr_data_i(hole_wr_data)
  );

endmodule

`default_nettype wire

// ===== src/bfha_chk.sv =====
// ----------------------------------------------------------------------------
// bfha_chk: port checker of the allocator
// Watches the request and response channels, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bfha_chk import bfha_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] payload_address_i,
  input logic [1:0]  status_i
);

  // a held response beat stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("response beat dropped while stalled");

  // a held response beat keeps its contents
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(payload_address_i) && $stable(status_i))
    else $error("response beat changed while stalled");

  // only one request is in work
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while another is in work");

  // failed requests return no address
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != ST_OK |-> payload_address_i == 32'h0)
    else $error("address returned on a failed request");

endmodule

bind best_fit_heap_allocator bfha_chk u_bfha_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (req_i.valid),
  .in_ready_i       (req_i.ready),
  .out_valid_i      (rsp_o.valid),
  .out_ready_i      (rsp_o.ready),
  .payload_address_i(rsp_o.payload_address),
  .status_i         (rsp_o.status)
);

`default_nettype wire
